// ===== rtl/olpf_pkg.sv =====
package olpf_pkg;

    // Default sizing of the list
    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 16;

    // Fixed field widths on the stream ports
    localparam int VALUE_W  = 16;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED   = 3'd0,
        STAT_FULL       = 3'd1,
        STAT_REMOVED    = 3'd2,
        STAT_NOT_FOUND  = 3'd3,
        STAT_EMPTY      = 3'd4,
        STAT_READ_OK    = 3'd5,
        STAT_READ_RANGE = 3'd6,
        STAT_CLEARED    = 3'd7
    } status_t;

    // Result status and fill level handed from the sequencer to the output stage
    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   count;
    } res_ctl_t;

endpackage

// ===== rtl/olpf_mem.sv =====
module olpf_mem #(
    parameter int DEPTH      = olpf_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = olpf_pkg::VALUE_BITS_DEF,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [VALUE_BITS-1:0] wdata,
    input  logic [AW-1:0]         raddr,
    output logic [VALUE_BITS-1:0] rdata
);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/olpf_ctrl.sv =====
module olpf_ctrl #(
    parameter int DEPTH      = olpf_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = olpf_pkg::VALUE_BITS_DEF,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // incoming transaction
    input  logic                            in_valid,
    output logic                            in_ready,
    input  olpf_pkg::action_t               in_action,
    input  logic [VALUE_BITS-1:0]           in_key,
    input  logic [olpf_pkg::POS_W-1:0]      in_pos,
    // result toward the output stage
    output logic                            res_valid,
    input  logic                            res_ready,
    output olpf_pkg::res_ctl_t              res_ctl,
    output logic [VALUE_BITS-1:0]           res_value,
    // memory port
    output logic                            mem_we,
    output logic [AW-1:0]                   mem_waddr,
    output logic [VALUE_BITS-1:0]           mem_wdata,
    output logic [AW-1:0]                   mem_raddr,
    input  logic [VALUE_BITS-1:0]           mem_rdata
);

    import olpf_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t                 state_reg,  state_next;
    logic [AW-1:0]          head_reg,   head_next;
    logic [CW-1:0]          count_reg,  count_next;
    logic [CW-1:0]          idx_reg,    idx_next;
    logic [VALUE_BITS-1:0]  key_reg,    key_next;
    status_t                status_reg, status_next;
    logic [VALUE_BITS-1:0]  value_reg,  value_next;

    logic [AW-1:0]          head_dec;
    logic [CW-1:0]          idx_p1;
    logic [CW-1:0]          idx_p2;
    logic [CW-1:0]          count_m1;

    // Map a list position onto the circular buffer
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = {1'b0, base} + SW'(off);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign idx_p1   = idx_reg + CW'(1);
    assign idx_p2   = idx_reg + CW'(2);
    assign count_m1 = count_reg - CW'(1);

    assign in_ready          = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_DONE);
    assign res_ctl.status    = status_reg;
    assign res_ctl.count     = COUNT_W'(count_reg);
    assign res_value         = value_reg;

    // Sequence one transaction through the shared compare and address unit
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        status_next = status_reg;
        value_next  = value_reg;
        mem_we      = 1'b0;
        mem_waddr   = phys(head_reg, idx_reg);
        mem_wdata   = mem_rdata;
        mem_raddr   = phys(head_reg, idx_p1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next   = in_key;
                    idx_next   = '0;
                    value_next = '0;
                    case (in_action)
                        ACT_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = head_dec;
                                mem_wdata   = in_key;
                                head_next   = head_dec;
                                count_next  = count_reg + CW'(1);
                                status_next = STAT_INSERTED;
                            end
                            state_next = S_DONE;
                        end
                        ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                mem_raddr  = head_reg;
                                state_next = S_SCAN;
                            end
                        end
                        ACT_READ:
                        begin
                            if (32'(in_pos) < 32'(count_reg))
                            begin
                                mem_raddr  = phys(head_reg, CW'(in_pos));
                                state_next = S_READ;
                            end
                            else
                            begin
                                status_next = STAT_READ_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                            count_next  = '0;
                            status_next = STAT_CLEARED;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                value_next  = mem_rdata;
                status_next = STAT_READ_OK;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                // compare one entry a cycle while the next one is fetched
                if (mem_rdata == key_reg)
                begin
                    if (idx_reg == count_m1)
                    begin
                        count_next  = count_m1;
                        status_next = STAT_REMOVED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_reg == count_m1)
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end
            S_SHIFT:
            begin
                // move the following entry one place toward the front
                mem_we    = 1'b1;
                mem_raddr = phys(head_reg, idx_p2);
                if (idx_p2 == count_reg)
                begin
                    count_next  = count_m1;
                    status_next = STAT_REMOVED;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, list bookkeeping and the pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= STAT_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

// ===== rtl/ordered_list_push_front_remove_core.sv =====
// Ordered list of up to DEPTH values, newest at the front.
// Input stream s_axis: tuser carries the action (insert at front, remove first
// match, read position, clear); tdata carries the value or key and the position.
// Output stream m_axis: one result transaction per input transaction, with the
// status in tuser and the read value and the resulting fill count in tdata.
// The list sits in a circular buffer memory with one registered read port and
// one write port; a small sequencer and a single comparator do all the work.
// One transaction is taken at a time; s_axis_tready is low while it runs.
// Insert, clear and the rejected cases go straight to the result; a read first
// waits for the registered memory data; a remove scans the entries up to the
// match and then closes the gap over the rest, one entry per cycle.
// The result sits in an output register; a stalled receiver holds it there,
// and the block finishes the next transaction and waits with it until the
// register drains. Reset empties the list at once; memory contents are never
// cleared, since only entries below the count are ever read.
module ordered_list_push_front_remove_core #(
    parameter int DEPTH      = olpf_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = olpf_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [olpf_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // value[15:0], position[19:16]
    input  logic [olpf_pkg::ACTION_W-1:0]    s_axis_tuser,  // action[1:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [olpf_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // value_out[15:0], count[20:16]
    output logic [olpf_pkg::STATUS_W-1:0]    m_axis_tuser   // status[2:0]
);

    import olpf_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int PAD_W = VALUE_BITS + VALUE_W;

    logic [PAD_W-1:0]       key_wide;
    logic [VALUE_BITS-1:0]  key;
    logic                   res_valid;
    logic                   res_ready;
    res_ctl_t               res_ctl;
    logic [VALUE_BITS-1:0]  res_value;
    logic [PAD_W-1:0]       val_wide;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_BITS-1:0]  mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_BITS-1:0]  mem_rdata;

    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [STATUS_W-1:0]    m_tuser_reg;

    // Keep only the low VALUE_BITS of the incoming value
    assign key_wide = {{VALUE_BITS{1'b0}}, s_axis_tdata[VALUE_W-1:0]};
    assign key      = key_wide[VALUE_BITS-1:0];

    olpf_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (action_t'(s_axis_tuser)),
        .in_key    (key),
        .in_pos    (s_axis_tdata[VALUE_W +: POS_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_ctl   (res_ctl),
        .res_value (res_value),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    olpf_mem #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Fit the stored value to the output field
    assign val_wide  = {{VALUE_W{1'b0}}, res_value};
    assign res_ready = !m_valid_reg || m_axis_tready;

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}},
                            res_ctl.count, val_wide[VALUE_W-1:0]};
            m_tuser_reg <= res_ctl.status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule
